@@ rtl/rsg_pkg.sv @@
package rsg_pkg;

	localparam int IDX_W   = 10;
	localparam int DATA_W  = 16;
	localparam int GATE_W  = 24;
	localparam int ALPHA_W = 16;

	localparam int STORE_DEPTH = 1 << IDX_W;
	localparam int QUEUE_DEPTH = 4;

	localparam int BATCH_COUNT_DEF      = 4;
	localparam int VECTOR_DIM_DEF       = 256;
	localparam int SIGMOID_SEGMENTS_DEF = 64;

	localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd4096;

	localparam logic CMD_STEP = 1'b0;
	localparam logic CMD_LOAD = 1'b1;

	// sigmoid table geometry, q8.8 input from -8 to 8
	localparam int KNOT_SPAN   = 4096;
	localparam int KNOT_HALF   = 2048;
	localparam int KNOT_SHIFT  = 12;
	localparam int SIG_W       = 17;
	localparam int SIG_ONE     = 65536;
	localparam int RECIP_SHIFT = 35;
	localparam int RECIP_W     = 32;

	localparam longint unsigned EXP_STEP_Q32 = 64'd4278222805;
	localparam longint unsigned ONE_Q32      = 64'd4294967296;

	typedef enum logic [1:0] {
		OP_STEP = 2'b00,
		OP_LOAD = 2'b01,
		OP_SKIP = 2'b10
	} op_t;

	typedef struct packed {
		op_t                      op;
		logic [IDX_W-1:0]         idx;
		logic signed [DATA_W-1:0] wx;
	} item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] h;
		logic                     clip;
	} hid_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] hidden;
		logic [GATE_W-1:0]        gated;
		logic                     saturated;
	} res_t;

	// exp(-t/256) in q0.32 by binary powering, truncating products
	function automatic longint unsigned exp_neg_q32(input int unsigned t);
		longint unsigned r;
		longint unsigned p;
		r = ONE_Q32;
		p = EXP_STEP_Q32;
		for (int i = 0; i < 12; i++) begin
			if (((t >> i) & 1) != 0) begin
				r = (r * p) >> 32;
			end
			p = (p * p) >> 32;
		end
		return r;
	endfunction

endpackage

@@ rtl/rsg_fifo.sv @@
module rsg_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = rsg_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int AW = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [AW:0]      count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == (AW+1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			count_q <= count_q + (AW+1)'(do_push) - (AW+1)'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

@@ rtl/rsg_front.sv @@
module rsg_front #(
	parameter int BATCH_COUNT = rsg_pkg::BATCH_COUNT_DEF,
	parameter int VECTOR_DIM  = rsg_pkg::VECTOR_DIM_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic                              cmd,
	input  logic [rsg_pkg::IDX_W-1:0]         element_index,
	input  logic signed [rsg_pkg::DATA_W-1:0] wx_value,
	input  logic                              head_pop,
	output logic                              head_valid,
	output rsg_pkg::item_t                    head
);

	localparam int unsigned TOTAL = BATCH_COUNT * VECTOR_DIM;

	rsg_pkg::item_t item;
	logic           oob;
	logic           q_empty;
	logic [$bits(rsg_pkg::item_t)-1:0] q_rdata;

	assign oob = (32'(element_index) >= 32'(TOTAL));

	always_comb begin
		item.idx = element_index;
		item.wx  = wx_value;
		if (oob) begin
			item.op = rsg_pkg::OP_SKIP;
		end else if (cmd == rsg_pkg::CMD_LOAD) begin
			item.op = rsg_pkg::OP_LOAD;
		end else begin
			item.op = rsg_pkg::OP_STEP;
		end
	end

	rsg_fifo #(
		.WIDTH($bits(rsg_pkg::item_t)),
		.DEPTH(rsg_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (item),
		.full  (full),
		.pop   (head_pop),
		.rdata (q_rdata),
		.empty (q_empty)
	);

	assign head_valid = !q_empty;
	assign head       = rsg_pkg::item_t'(q_rdata);

endmodule

@@ rtl/rsg_hidden.sv @@
module rsg_hidden (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              adv,
	input  logic [rsg_pkg::ALPHA_W-1:0]       alpha_gain,
	input  logic                              head_valid,
	input  rsg_pkg::item_t                    head,
	output logic                              head_pop,
	output logic                              v_s2,
	output rsg_pkg::hid_t                     hid_s2
);

	logic [rsg_pkg::DATA_W-1:0] mem_q [rsg_pkg::STORE_DEPTH];

	logic                              v_s1;
	rsg_pkg::item_t                    item_s1;
	logic signed [32:0]                prod_s1;
	logic [rsg_pkg::DATA_W-1:0]        rd_s1;
	logic                              wr_s2;
	logic [rsg_pkg::IDX_W-1:0]         idx_s2;

	logic signed [32:0]                prod;
	logic signed [rsg_pkg::DATA_W-1:0] prev;
	logic signed [32:0]                rnd;
	logic signed [21:0]                inc;
	logic signed [22:0]                sum;
	rsg_pkg::hid_t                     hid;
	logic                              wr;

	assign head_pop = adv && head_valid;
	assign prod     = 33'($signed({1'b0, alpha_gain})) * 33'(head.wx);

	// newest value of the element, bypassing the write that lands with the read
	assign prev = (v_s2 && wr_s2 && (idx_s2 == item_s1.idx)) ? hid_s2.h : $signed(rd_s1);
	assign rnd  = prod_s1 + 33'sd2048;
	assign inc  = 22'(rnd >>> 12);
	assign sum  = 23'(prev) + 23'(inc);

	always_comb begin
		hid.h    = '0;
		hid.clip = 1'b0;
		wr       = 1'b0;
		case (item_s1.op)
			rsg_pkg::OP_LOAD: begin
				hid.h = item_s1.wx;
				wr    = 1'b1;
			end
			rsg_pkg::OP_STEP: begin
				wr = 1'b1;
				if (sum > 23'sd32767) begin
					hid.h    = 16'sh7fff;
					hid.clip = 1'b1;
				end else if (sum < -23'sd32768) begin
					hid.h    = -16'sh8000;
					hid.clip = 1'b1;
				end else begin
					hid.h = 16'(sum);
				end
			end
			default: begin
				hid.h = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= head_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= head;
			prod_s1 <= prod;
			rd_s1   <= mem_q[head.idx];
			hid_s2  <= hid;
			wr_s2   <= wr;
			idx_s2  <= item_s1.idx;
			if (v_s1 && wr) begin
				mem_q[item_s1.idx] <= hid.h;
			end
		end
	end

endmodule

@@ rtl/rsg_gate.sv @@
module rsg_gate #(
	parameter int SIGMOID_SEGMENTS = rsg_pkg::SIGMOID_SEGMENTS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  logic          v_s2,
	input  rsg_pkg::hid_t hid_s2,
	output logic          v_s8,
	output rsg_pkg::res_t res_s8
);

	localparam int SEGS = SIGMOID_SEGMENTS;
	localparam int KW   = $clog2(SEGS);
	localparam int PW   = KW + 14;
	localparam int SW   = rsg_pkg::SIG_W;

	logic [SW-1:0]               knot_val [SEGS+1];
	logic [12:0]                 knot_off [SEGS+1];
	logic [SW-1:0]               seg_base [SEGS];
	logic signed [SW:0]          seg_d    [SEGS];
	logic [rsg_pkg::RECIP_W-1:0] seg_rcp  [SEGS];

	// knot values of the sigmoid, fixed at elaboration
	for (genvar k = 0; k <= SEGS; k++) begin : g_knot
		localparam int U   = (rsg_pkg::KNOT_SPAN * k) / SEGS;
		localparam int POS = U - rsg_pkg::KNOT_HALF;
		localparam int T   = (POS < 0) ? -POS : POS;
		localparam longint unsigned DEN = rsg_pkg::ONE_Q32 + rsg_pkg::exp_neg_q32(T);
		localparam longint unsigned SV  = ((64'd1 << 48) + (DEN >> 1)) / DEN;
		localparam longint unsigned KV  = (POS < 0) ? (64'(rsg_pkg::SIG_ONE) - SV) : SV;
		assign knot_val[k] = SW'(KV);
		assign knot_off[k] = 13'(U);
	end

	for (genvar k = 0; k < SEGS; k++) begin : g_seg
		localparam int W0 = (rsg_pkg::KNOT_SPAN * k) / SEGS;
		localparam int W1 = (rsg_pkg::KNOT_SPAN * (k + 1)) / SEGS;
		localparam longint unsigned RCP =
			((64'd1 << rsg_pkg::RECIP_SHIFT) + 64'(W1 - W0) - 64'd1) / 64'(W1 - W0);
		assign seg_base[k] = knot_val[k];
		assign seg_d[k]    = $signed({1'b0, knot_val[k+1]}) - $signed({1'b0, knot_val[k]});
		assign seg_rcp[k]  = rsg_pkg::RECIP_W'(RCP);
	end

	// stage 3: square, segment search
	logic                v_s3;
	rsg_pkg::hid_t       hid_s3;
	logic [30:0]         sq_s3;
	logic [11:0]         u_s3;
	logic [KW-1:0]       k_s3;
	logic                below_s3;
	logic                above_s3;

	logic signed [16:0]  u;
	logic [PW-1:0]       kprod;
	logic [PW-13:0]      kraw;
	logic [KW-1:0]       seg_k;
	logic [31:0]         sq;

	assign u     = 17'(hid_s2.h) + 17'sd2048;
	assign kprod = (PW'(u[11:0]) + PW'(1)) * PW'(SEGS) - PW'(1);
	assign kraw  = kprod[PW-1:12];
	assign seg_k = (kraw >= (PW-12)'(SEGS)) ? KW'(SEGS - 1) : KW'(kraw);
	assign sq    = 32'(hid_s2.h) * 32'(hid_s2.h);

	// stage 4: slope times offset
	logic                v_s4;
	rsg_pkg::hid_t       hid_s4;
	logic [30:0]         sq_s4;
	logic [26:0]         n_s4;
	logic                neg_s4;
	logic [SW-1:0]       base_s4;
	logic [rsg_pkg::RECIP_W-1:0] rcp_s4;

	logic signed [SW:0]  d;
	logic [SW-1:0]       dm;
	logic [11:0]         t_full;
	logic [9:0]          t;

	assign d      = seg_d[k_s3];
	assign dm     = d[SW] ? SW'(-d) : SW'(d);
	assign t_full = u_s3 - knot_off[k_s3][11:0];
	assign t      = t_full[9:0];

	// stage 5: divide by segment width through its reciprocal
	logic                v_s5;
	rsg_pkg::hid_t       hid_s5;
	logic [30:0]         sq_s5;
	logic                neg_s5;
	logic [SW-1:0]       base_s5;
	logic [SW-1:0]       q_s5;
	logic [58:0]         qprod;

	assign qprod = 59'(n_s4) * 59'(rcp_s4);

	// stage 6: sigmoid value
	logic                v_s6;
	rsg_pkg::hid_t       hid_s6;
	logic [30:0]         sq_s6;
	logic [SW-1:0]       sig_s6;
	logic signed [SW+1:0] y;
	logic [SW-1:0]       sig;

	assign y = neg_s5 ? ($signed({2'b00, base_s5}) - $signed({2'b00, q_s5}))
	                  : ($signed({2'b00, base_s5}) + $signed({2'b00, q_s5}));

	always_comb begin
		if (y < 0) begin
			sig = '0;
		end else if (y > (SW+2)'(rsg_pkg::SIG_ONE)) begin
			sig = SW'(rsg_pkg::SIG_ONE);
		end else begin
			sig = SW'(y);
		end
	end

	// stage 7: square times sigmoid, stage 8: round to q16.8
	logic                v_s7;
	rsg_pkg::hid_t       hid_s7;
	logic [47:0]         gprod_s7;
	logic [47:0]         grnd;

	assign grnd = gprod_s7 + 48'd8388608;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hid_s3   <= hid_s2;
			sq_s3    <= sq[30:0];
			u_s3     <= u[11:0];
			k_s3     <= seg_k;
			below_s3 <= u[16] || (u == '0);
			above_s3 <= !u[16] && (u[15:12] != '0);

			hid_s4 <= hid_s3;
			sq_s4  <= sq_s3;
			neg_s4 <= d[SW];
			rcp_s4 <= seg_rcp[k_s3];
			if (below_s3) begin
				n_s4    <= '0;
				base_s4 <= knot_val[0];
			end else if (above_s3) begin
				n_s4    <= '0;
				base_s4 <= knot_val[SEGS];
			end else begin
				n_s4    <= 27'(dm) * 27'(t);
				base_s4 <= seg_base[k_s3];
			end

			hid_s5  <= hid_s4;
			sq_s5   <= sq_s4;
			neg_s5  <= neg_s4;
			base_s5 <= base_s4;
			q_s5    <= SW'(qprod >> rsg_pkg::RECIP_SHIFT);

			hid_s6 <= hid_s5;
			sq_s6  <= sq_s5;
			sig_s6 <= sig;

			hid_s7   <= hid_s6;
			gprod_s7 <= 48'(sq_s6) * 48'(sig_s6);

			res_s8.hidden    <= hid_s7.h;
			res_s8.gated     <= grnd[47:24];
			res_s8.saturated <= hid_s7.clip;
		end
	end

endmodule

@@ rtl/residual_recurrence_silu_gate.sv @@
// Residual recurrence with a self-gate over a 1024 x 16 bit hidden store in Q8.8. A step word
// adds round(alpha_gain * wx_value) to the stored element, saturates, stores and returns it
// along with the gate h*h*sigmoid(h) in Q16.8, sigmoid coming from a piecewise-linear table;
// a load word stores wx_value as is, and an index beyond BATCH_COUNT*VECTOR_DIM returns all
// zeros and writes nothing. The block takes one word per clock while full is low and
// returns one result per clock while the back end does not stall; a result passes through
// the four-word input queue, an eight-stage back end that reads the store in its first
// stage and writes it in the second, and the output queue. Back-to-back words
// on the same element are handled by forwarding inside the back end. The back end stalls as a
// whole only while its last stage holds a result and the output queue is full; full rises
// when the input queue holds four words. An element must be loaded before it is stepped.
// alpha_gain resets to 1.0 and is written through cfg_valid / cfg_ready, which is always ready.
module residual_recurrence_silu_gate #(
	parameter int BATCH_COUNT      = rsg_pkg::BATCH_COUNT_DEF,
	parameter int VECTOR_DIM       = rsg_pkg::VECTOR_DIM_DEF,
	parameter int SIGMOID_SEGMENTS = rsg_pkg::SIGMOID_SEGMENTS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic                              cmd,
	input  logic [rsg_pkg::IDX_W-1:0]         element_index,
	input  logic signed [rsg_pkg::DATA_W-1:0] wx_value,
	output logic                              empty,
	input  logic                              pop,
	output logic signed [rsg_pkg::DATA_W-1:0] hidden_out,
	output logic [rsg_pkg::GATE_W-1:0]        gated_out,
	output logic                              saturated,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [rsg_pkg::ALPHA_W-1:0]       cfg_data
);

	logic [rsg_pkg::ALPHA_W-1:0] alpha_q;
	logic                        head_valid;
	rsg_pkg::item_t              head;
	logic                        head_pop;
	logic                        adv;
	logic                        v_s2;
	rsg_pkg::hid_t               hid_s2;
	logic                        v_s8;
	rsg_pkg::res_t               res_s8;
	logic                        out_full;
	logic [$bits(rsg_pkg::res_t)-1:0] out_rdata;
	rsg_pkg::res_t               res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= rsg_pkg::ALPHA_RESET;
		end else if (cfg_valid && cfg_ready) begin
			alpha_q <= cfg_data;
		end
	end

	assign adv = !v_s8 || !out_full;

	rsg_front #(
		.BATCH_COUNT(BATCH_COUNT),
		.VECTOR_DIM (VECTOR_DIM)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.cmd          (cmd),
		.element_index(element_index),
		.wx_value     (wx_value),
		.head_pop     (head_pop),
		.head_valid   (head_valid),
		.head         (head)
	);

	rsg_hidden u_hidden (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.alpha_gain(alpha_q),
		.head_valid(head_valid),
		.head      (head),
		.head_pop  (head_pop),
		.v_s2      (v_s2),
		.hid_s2    (hid_s2)
	);

	rsg_gate #(
		.SIGMOID_SEGMENTS(SIGMOID_SEGMENTS)
	) u_gate (
		.clk   (clk),
		.arst_n(arst_n),
		.adv   (adv),
		.v_s2  (v_s2),
		.hid_s2(hid_s2),
		.v_s8  (v_s8),
		.res_s8(res_s8)
	);

	rsg_fifo #(
		.WIDTH($bits(rsg_pkg::res_t)),
		.DEPTH(rsg_pkg::QUEUE_DEPTH)
	) u_out_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (v_s8),
		.wdata (res_s8),
		.full  (out_full),
		.pop   (pop),
		.rdata (out_rdata),
		.empty (empty)
	);

	assign res        = rsg_pkg::res_t'(out_rdata);
	assign hidden_out = res.hidden;
	assign gated_out  = res.gated;
	assign saturated  = res.saturated;

endmodule
